// ===== hw/rtl/onewire_bus_master_core_assert.svh =====
// assertion macros for the one-wire bus master
`ifndef ONEWIRE_BUS_MASTER_CORE_ASSERT_SVH
`define ONEWIRE_BUS_MASTER_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define OWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("onewire bus master: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("onewire bus master: next-cycle check failed");

`endif

// ===== hw/rtl/owm_pkg.sv =====
// shared types and constants of the one-wire bus master
`timescale 1ns / 1ps

package owm_pkg;

   // widest timing register
   localparam int CFG_W = 10;

   localparam int RESET_LOW_W  = 10;
   localparam int PRESENCE_W   = 10;
   localparam int RECOVERY_W   = 10;
   localparam int SLOT_START_W = 6;
   localparam int SLOT_SAMPLE_W = 8;
   localparam int SLOT_TOTAL_W = 8;

   localparam logic [RESET_LOW_W-1:0]   RESET_LOW_DEF   = 10'd480;
   localparam logic [PRESENCE_W-1:0]    PRESENCE_DEF    = 10'd66;
   localparam logic [RECOVERY_W-1:0]    RECOVERY_DEF    = 10'd414;
   localparam logic [SLOT_START_W-1:0]  SLOT_START_DEF  = 6'd1;
   localparam logic [SLOT_SAMPLE_W-1:0] SLOT_SAMPLE_DEF = 8'd15;
   localparam logic [SLOT_TOTAL_W-1:0]  SLOT_TOTAL_DEF  = 8'd60;

   // register indexes
   localparam logic [2:0] REG_RESET_LOW   = 3'd0;
   localparam logic [2:0] REG_PRESENCE    = 3'd1;
   localparam logic [2:0] REG_RECOVERY    = 3'd2;
   localparam logic [2:0] REG_SLOT_START  = 3'd3;
   localparam logic [2:0] REG_SLOT_SAMPLE = 3'd4;
   localparam logic [2:0] REG_SLOT_TOTAL  = 3'd5;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_BYTE  = 2'd2;

   // reset status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_PRES  = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;

   typedef struct packed {
      logic [RESET_LOW_W-1:0]   reset_low;
      logic [PRESENCE_W-1:0]    presence;
      logic [RECOVERY_W-1:0]    recovery;
      logic [SLOT_START_W-1:0]  slot_start;
      logic [SLOT_SAMPLE_W-1:0] slot_sample;
      logic [SLOT_TOTAL_W-1:0]  slot_total;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       ignored;
   } result_type;

endpackage

// ===== hw/rtl/owm_csr.sv =====
// timing register file behind the apb-style port
`timescale 1ns / 1ps

module owm_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output owm_pkg::cfg_type     cfg
);

   owm_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr_en;

   assign idx   = csr_paddr[4:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            owm_pkg::REG_RESET_LOW:
               cfg_in.reset_low = csr_pwdata[owm_pkg::RESET_LOW_W-1:0];
            owm_pkg::REG_PRESENCE:
               cfg_in.presence = csr_pwdata[owm_pkg::PRESENCE_W-1:0];
            owm_pkg::REG_RECOVERY:
               cfg_in.recovery = csr_pwdata[owm_pkg::RECOVERY_W-1:0];
            owm_pkg::REG_SLOT_START:
               cfg_in.slot_start = csr_pwdata[owm_pkg::SLOT_START_W-1:0];
            owm_pkg::REG_SLOT_SAMPLE:
               cfg_in.slot_sample = csr_pwdata[owm_pkg::SLOT_SAMPLE_W-1:0];
            owm_pkg::REG_SLOT_TOTAL:
               cfg_in.slot_total = csr_pwdata[owm_pkg::SLOT_TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low   <= owm_pkg::RESET_LOW_DEF;
         cfg_ff.presence    <= owm_pkg::PRESENCE_DEF;
         cfg_ff.recovery    <= owm_pkg::RECOVERY_DEF;
         cfg_ff.slot_start  <= owm_pkg::SLOT_START_DEF;
         cfg_ff.slot_sample <= owm_pkg::SLOT_SAMPLE_DEF;
         cfg_ff.slot_total  <= owm_pkg::SLOT_TOTAL_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         owm_pkg::REG_RESET_LOW:   csr_prdata = 32'(cfg_ff.reset_low);
         owm_pkg::REG_PRESENCE:    csr_prdata = 32'(cfg_ff.presence);
         owm_pkg::REG_RECOVERY:    csr_prdata = 32'(cfg_ff.recovery);
         owm_pkg::REG_SLOT_START:  csr_prdata = 32'(cfg_ff.slot_start);
         owm_pkg::REG_SLOT_SAMPLE: csr_prdata = 32'(cfg_ff.slot_sample);
         owm_pkg::REG_SLOT_TOTAL:  csr_prdata = 32'(cfg_ff.slot_total);
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/owm_engine.sv =====
// bus sequencer: reset pulse and byte slots, advanced one beat per step
`timescale 1ns / 1ps

module owm_engine #(
   parameter int TIMER_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           cmd,
   input  logic [7:0]           byte_value,
   input  logic                 line_level,
   input  owm_pkg::cfg_type     cfg,
   output owm_pkg::result_type  res
);

   `include "onewire_bus_master_core_assert.svh"

   localparam int CmpW = (TIMER_BITS > owm_pkg::CFG_W) ? TIMER_BITS : owm_pkg::CFG_W;
   localparam logic [TIMER_BITS-1:0] CntMax = {TIMER_BITS{1'b1}};

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_RST_LOW   = 8'b0000_0010,
      PH_RST_WAIT  = 8'b0000_0100,
      PH_RST_RECOV = 8'b0000_1000,
      PH_SLOT_LOW  = 8'b0001_0000,
      PH_SLOT_WAIT = 8'b0010_0000,
      PH_SLOT_REST = 8'b0100_0000,
      PH_SLOT_GAP  = 8'b1000_0000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] count_ff, count_in, count_inc;
   logic [7:0]            shift_ff, shift_in, shift_next;
   logic [3:0]            bits_ff, bits_in, bits_dec;
   logic                  nopres_ff, nopres_in;
   logic                  slot_bit_ff, slot_bit_in;
   logic                  drive_ff, drive_in;
   logic                  done, ignored;
   logic [1:0]            status;
   logic [7:0]            rbyte;

   // a limit the saturated counter cannot reach counts as reached
   function automatic logic reached(input logic [TIMER_BITS-1:0] cnt,
                                    input logic [owm_pkg::CFG_W-1:0] limit);
      logic [CmpW-1:0] c;
      logic [CmpW-1:0] l;
      c = CmpW'(cnt);
      l = CmpW'(limit);
      return (c >= l) || (cnt == CntMax);
   endfunction

   assign count_inc  = (count_ff == CntMax) ? count_ff : count_ff + TIMER_BITS'(1);
   assign shift_next = {slot_bit_ff, shift_ff[7:1]};
   assign bits_dec   = bits_ff - 4'd1;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      bits_in     = bits_ff;
      nopres_in   = nopres_ff;
      slot_bit_in = slot_bit_ff;
      drive_in    = drive_ff;
      done        = 1'b0;
      ignored     = 1'b0;
      status      = owm_pkg::STATUS_OK;
      rbyte       = 8'd0;

      if (cmd == owm_pkg::CMD_RESET || cmd == owm_pkg::CMD_BYTE) begin
         if (phase_ff != PH_IDLE) begin
            ignored = 1'b1;
         end else if (cmd == owm_pkg::CMD_RESET) begin
            drive_in  = 1'b1;
            count_in  = '0;
            nopres_in = 1'b0;
            phase_in  = PH_RST_LOW;
         end else begin
            shift_in    = byte_value;
            bits_in     = 4'd8;
            slot_bit_in = byte_value[0];
            drive_in    = 1'b1;
            count_in    = '0;
            phase_in    = PH_SLOT_LOW;
         end
      end else if (cmd == owm_pkg::CMD_TICK && phase_ff != PH_IDLE) begin
         count_in = count_inc;
         unique case (phase_ff)
            PH_RST_LOW: begin
               if (reached(count_inc, cfg.reset_low)) begin
                  drive_in = 1'b0;
                  count_in = '0;
                  phase_in = PH_RST_WAIT;
               end
            end
            PH_RST_WAIT: begin
               if (reached(count_inc, cfg.presence)) begin
                  nopres_in = line_level;
                  count_in  = '0;
                  phase_in  = PH_RST_RECOV;
               end
            end
            PH_RST_RECOV: begin
               if (reached(count_inc, cfg.recovery)) begin
                  // a line held low wins over a missing presence pulse
                  status   = !line_level ? owm_pkg::STATUS_SHORT
                           : (nopres_ff ? owm_pkg::STATUS_NO_PRES : owm_pkg::STATUS_OK);
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            PH_SLOT_LOW: begin
               if (reached(count_inc, owm_pkg::CFG_W'(cfg.slot_start))) begin
                  if (slot_bit_ff) begin
                     drive_in = 1'b0;
                  end
                  phase_in = PH_SLOT_WAIT;
               end
            end
            PH_SLOT_WAIT: begin
               if (reached(count_inc, owm_pkg::CFG_W'(cfg.slot_sample))) begin
                  if (!line_level) begin
                     slot_bit_in = 1'b0;
                  end
                  phase_in = PH_SLOT_REST;
               end
            end
            PH_SLOT_REST: begin
               if (reached(count_inc, owm_pkg::CFG_W'(cfg.slot_total))) begin
                  drive_in = 1'b0;
                  shift_in = shift_next;
                  bits_in  = bits_dec;
                  if (bits_dec == 4'd0) begin
                     done     = 1'b1;
                     rbyte    = shift_next;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_SLOT_GAP;
                  end
               end
            end
            PH_SLOT_GAP: begin
               slot_bit_in = shift_ff[0];
               drive_in    = 1'b1;
               count_in    = '0;
               phase_in    = PH_SLOT_LOW;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         shift_ff    <= 8'd0;
         bits_ff     <= 4'd0;
         nopres_ff   <= 1'b0;
         slot_bit_ff <= 1'b0;
         drive_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         shift_ff    <= shift_in;
         bits_ff     <= bits_in;
         nopres_ff   <= nopres_in;
         slot_bit_ff <= slot_bit_in;
         drive_ff    <= drive_in;
      end
   end

   assign res.drive_low = drive_in;
   assign res.busy_res  = (phase_in != PH_IDLE);
   assign res.done_res  = done;
   assign res.status    = status;
   assign res.read_byte = rbyte;
   assign res.ignored   = ignored;

   `OWM_ASSERT_NEXT(a_done_to_idle, clock, reset, step && done, phase_ff == PH_IDLE)
   `OWM_ASSERT_NOW(a_slot_bits_left, clock, reset,
      phase_ff == PH_SLOT_LOW || phase_ff == PH_SLOT_WAIT ||
      phase_ff == PH_SLOT_REST || phase_ff == PH_SLOT_GAP, bits_ff != 4'd0)
   `OWM_ASSERT_NOW(a_reset_low_drives, clock, reset, phase_ff == PH_RST_LOW, drive_ff)
   `OWM_ASSERT_NOW(a_ignore_when_busy, clock, reset, ignored, phase_ff != PH_IDLE)
   `OWM_ASSERT_NOW(a_status_on_done, clock, reset, status != owm_pkg::STATUS_OK, done)

endmodule

// ===== hw/rtl/onewire_bus_master_core.sv =====
// One-wire bus master. Each request beat is either a one-microsecond tick
// carrying the sampled bus level or a start command (bus reset or byte
// exchange); every request beat yields exactly one response beat with the
// drive level, busy, done, reset status, received byte and ignored flag.
// One beat is taken per clock cycle unless the input is held off: the beat
// is registered at the input, the sequencer updates its state as the beat
// moves on, and the response sits in an output register, so the response
// is offered after its beat has passed the input and output registers, and
// a stalled response holds off the input only once the input register is also full.
`timescale 1ns / 1ps

module onewire_bus_master_core #(
   parameter int TIMER_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_byte_value,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drive_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_ignored,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   owm_pkg::cfg_type    cfg;
   owm_pkg::result_type res, res_ff;

   logic       in_vld_ff, in_vld_in;
   logic [1:0] cmd_ff;
   logic [7:0] byte_ff;
   logic       line_ff;
   logic       out_vld_ff, out_vld_in;
   logic       step;

   // the held beat moves on when the response register is free or draining
   assign step      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step;

   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !step);
   assign out_vld_in = step || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_cmd;
         byte_ff <= req_byte_value;
         line_ff <= req_line_level;
      end
      if (step) begin
         res_ff <= res;
      end
   end

   owm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   owm_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (cmd_ff),
      .byte_value (byte_ff),
      .line_level (line_ff),
      .cfg        (cfg),
      .res        (res)
   );

   assign rsp_valid     = out_vld_ff;
   assign rsp_drive_low = res_ff.drive_low;
   assign rsp_busy_res  = res_ff.busy_res;
   assign rsp_done_res  = res_ff.done_res;
   assign rsp_status    = res_ff.status;
   assign rsp_read_byte = res_ff.read_byte;
   assign rsp_ignored   = res_ff.ignored;

endmodule
